// File: sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define GSP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication.
`define GSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: sv/gsp_pkg.sv
package gsp_pkg;

   localparam int MAX_TASKS_DEF = 16;

   localparam int LEN_W     = 16;
   localparam int DL_W      = 20;
   localparam int CNT_W     = 5;
   localparam int TIDX_W    = 4;
   localparam int WORKER_W  = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_DEADLINE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TASK_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WORKER_COUNT = 2'd2;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_WORKER,
      ST_GATHER,
      ST_SEARCH,
      ST_COMMIT,
      ST_OUTPUT
   } state_type;

   // sequencer -> search unit
   typedef struct packed {
      logic clear;   // new worker: empty the open list
      logic push;    // append one open task length
      logic start;   // load the all-ones mask
      logic step;    // evaluate current mask, move to the next one
   } srch_ctl_type;

   // search unit -> sequencer
   typedef struct packed {
      logic done;    // enumeration ends this cycle
      logic empty;   // open list holds no task
   } srch_stat_type;

endpackage

// File: sv/gsp_subset_search.sv
module gsp_subset_search #(
   parameter int MAX_TASKS = gsp_pkg::MAX_TASKS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  gsp_pkg::srch_ctl_type      ctl,
   input  logic [gsp_pkg::LEN_W-1:0]  push_len,
   input  logic [gsp_pkg::DL_W-1:0]   deadline,
   output gsp_pkg::srch_stat_type     stat,
   output logic [MAX_TASKS-1:0]       best_mask
);
   import gsp_pkg::*;

   localparam int IDX_W  = $clog2(MAX_TASKS + 1);
   localparam int ADDR_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int SUM_W  = LEN_W + $clog2(MAX_TASKS);
   localparam int CMP_W  = (SUM_W > DL_W) ? SUM_W : DL_W;

   // delta[k] = (sum of open lengths below k) - length[k]
   // Decrementing the mask clears its lowest set bit k and sets all bits below,
   // so the subset sum moves by exactly delta[k].
   logic signed [SUM_W:0] delta_mem [MAX_TASKS];

   logic [IDX_W-1:0]     n_ff, n_in;
   logic [SUM_W-1:0]     total_ff, total_in;
   logic [MAX_TASKS-1:0] mask_ff, mask_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [SUM_W-1:0]     best_sum_ff, best_sum_in;
   logic [MAX_TASKS-1:0] best_mask_ff, best_mask_in;

   logic [ADDR_W-1:0]    lsb_idx;
   logic [MAX_TASKS-1:0] ones_mask;
   logic [SUM_W-1:0]     sum_next;
   logic [CMP_W-1:0]     sum_c, dl_c;
   logic                 hit, exact, last_mask;

   always_comb begin
      lsb_idx = '0;
      for (int j = MAX_TASKS - 1; j >= 0; j--) begin
         if (mask_ff[j]) begin
            lsb_idx = ADDR_W'(j);
         end
      end
   end

   always_comb begin
      for (int j = 0; j < MAX_TASKS; j++) begin
         ones_mask[j] = (IDX_W'(j) < n_ff);
      end
   end

   assign sum_next  = SUM_W'($signed({1'b0, sum_ff}) + delta_mem[lsb_idx]);
   assign sum_c     = CMP_W'(sum_ff);
   assign dl_c      = CMP_W'(deadline);
   assign hit       = (sum_c <= dl_c) && (sum_ff > best_sum_ff);
   assign exact     = (sum_c == dl_c);
   assign last_mask = (mask_ff == MAX_TASKS'(1));

   assign stat.done  = ctl.step && (exact || last_mask);
   assign stat.empty = (n_ff == '0);
   assign best_mask  = best_mask_ff;

   always_comb begin
      n_in         = n_ff;
      total_in     = total_ff;
      mask_in      = mask_ff;
      sum_in       = sum_ff;
      best_sum_in  = best_sum_ff;
      best_mask_in = best_mask_ff;
      if (ctl.clear) begin
         n_in     = '0;
         total_in = '0;
      end else if (ctl.push) begin
         n_in     = n_ff + 1'b1;
         total_in = total_ff + SUM_W'(push_len);
      end else if (ctl.start) begin
         mask_in      = ones_mask;
         sum_in       = total_ff;
         best_sum_in  = '0;
         best_mask_in = '0;
      end else if (ctl.step) begin
         if (hit) begin
            best_sum_in  = sum_ff;
            best_mask_in = mask_ff;
         end
         mask_in = mask_ff - 1'b1;
         sum_in  = sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= '0;
         total_ff     <= '0;
         mask_ff      <= '0;
         sum_ff       <= '0;
         best_sum_ff  <= '0;
         best_mask_ff <= '0;
      end else begin
         n_ff         <= n_in;
         total_ff     <= total_in;
         mask_ff      <= mask_in;
         sum_ff       <= sum_in;
         best_sum_ff  <= best_sum_in;
         best_mask_ff <= best_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         delta_mem[n_ff[ADDR_W-1:0]] <= $signed({1'b0, total_ff}) -
                                        $signed((SUM_W + 1)'(push_len));
      end
   end

endmodule

// File: sv/greedy_subset_sum_task_packer_unit.sv
// Load: one task length per cycle, req_stall low while loading.
// After the final length, per worker: gather the open tasks,
// subset search (one mask per cycle through one adder),
// and commit; n = open tasks, tc = effective task count.
// Then tc result words, one per cycle unless stalled. Input stalled meanwhile.
// Reset is synchronous, active high; the length store is not cleared.
module greedy_subset_sum_task_packer_unit #(
   parameter int MAX_TASKS = gsp_pkg::MAX_TASKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [gsp_pkg::LEN_W-1:0]       req_task_length,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [gsp_pkg::TIDX_W-1:0]      rsp_task_index,
   output logic [gsp_pkg::WORKER_W-1:0]    rsp_worker,
   output logic                            rsp_all_placed,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gsp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gsp_pkg::DL_W-1:0]        csr_data
);
   import gsp_pkg::*;

   localparam int IDX_W  = $clog2(MAX_TASKS + 1);
   localparam int ADDR_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

   logic [DL_W-1:0]  deadline_ff;
   logic [CNT_W-1:0] task_count_ff;
   logic [CNT_W-1:0] worker_count_ff;

   logic [LEN_W-1:0]    length_store [MAX_TASKS];
   logic [WORKER_W-1:0] assigned_ff  [MAX_TASKS];

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    load_ff, load_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [IDX_W-1:0]    placed_ff, placed_in;
   logic [CNT_W-1:0]    worker_ff, worker_in;

   logic [IDX_W-1:0]    eff_tc;
   logic [IDX_W-1:0]    load_next;
   logic [ADDR_W-1:0]   idx_a;
   logic                len_we, asg_we, asg_clr;
   logic                is_open;

   srch_ctl_type        ctl;
   srch_stat_type       stat;
   logic [MAX_TASKS-1:0] best_mask;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadline_ff     <= '0;
         task_count_ff   <= CNT_W'(1);
         worker_count_ff <= CNT_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEADLINE:     deadline_ff     <= csr_data;
            CSR_TASK_COUNT:   task_count_ff   <= csr_data[CNT_W-1:0];
            CSR_WORKER_COUNT: worker_count_ff <= csr_data[CNT_W-1:0];
            default:          ;
         endcase
      end
   end

   // zero counts as one, saturate at the store depth
   always_comb begin
      if (task_count_ff == '0) begin
         eff_tc = IDX_W'(1);
      end else if (int'(task_count_ff) > MAX_TASKS) begin
         eff_tc = IDX_W'(MAX_TASKS);
      end else begin
         eff_tc = IDX_W'(task_count_ff);
      end
   end

   assign load_next = load_ff + 1'b1;
   assign idx_a     = idx_ff[ADDR_W-1:0];
   assign is_open   = (assigned_ff[idx_a] == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      load_in   = load_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      placed_in = placed_ff;
      worker_in = worker_ff;
      ctl       = '0;
      len_we    = 1'b0;
      asg_we    = 1'b0;
      asg_clr   = 1'b0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               len_we  = (load_ff < IDX_W'(MAX_TASKS));
               load_in = load_next;
               if (load_next >= eff_tc) begin
                  load_in   = '0;
                  asg_clr   = 1'b1;
                  worker_in = '0;
                  placed_in = '0;
                  state_in  = ST_WORKER;
               end
            end
         end
         ST_WORKER: begin
            idx_in = '0;
            if (worker_ff >= worker_count_ff) begin
               state_in = ST_OUTPUT;
            end else begin
               ctl.clear = 1'b1;
               state_in  = ST_GATHER;
            end
         end
         ST_GATHER: begin
            if (idx_ff < eff_tc) begin
               ctl.push = is_open;
               idx_in   = idx_ff + 1'b1;
            end else if (stat.empty) begin
               worker_in = worker_ff + 1'b1;
               state_in  = ST_WORKER;
            end else begin
               ctl.start = 1'b1;
               state_in  = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            ctl.step = 1'b1;
            if (stat.done) begin
               idx_in   = '0;
               pos_in   = '0;
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            // pos walks the open list in step with idx over all tasks
            if (idx_ff < eff_tc) begin
               if (is_open) begin
                  if (best_mask[pos_ff[ADDR_W-1:0]]) begin
                     asg_we    = 1'b1;
                     placed_in = placed_ff + 1'b1;
                  end
                  pos_in = pos_ff + 1'b1;
               end
               idx_in = idx_ff + 1'b1;
            end else begin
               worker_in = worker_ff + 1'b1;
               state_in  = ST_WORKER;
            end
         end
         ST_OUTPUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               idx_in = idx_ff + 1'b1;
               if (rsp_last) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff   <= '0;
         idx_ff    <= '0;
         pos_ff    <= '0;
         placed_ff <= '0;
         worker_ff <= '0;
      end else begin
         load_ff   <= load_in;
         idx_ff    <= idx_in;
         pos_ff    <= pos_in;
         placed_ff <= placed_in;
         worker_ff <= worker_in;
      end
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         length_store[load_ff[ADDR_W-1:0]] <= req_task_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || asg_clr) begin
         for (int j = 0; j < MAX_TASKS; j++) begin
            assigned_ff[j] <= '0;
         end
      end else if (asg_we) begin
         assigned_ff[idx_a] <= worker_ff + 1'b1;
      end
   end

   gsp_subset_search #(
      .MAX_TASKS (MAX_TASKS)
   ) u_search (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .push_len  (length_store[idx_a]),
      .deadline  (deadline_ff),
      .stat      (stat),
      .best_mask (best_mask)
   );

   assign rsp_task_index = TIDX_W'(idx_ff);
   assign rsp_worker     = assigned_ff[idx_a];
   assign rsp_all_placed = (placed_ff == eff_tc);
   assign rsp_last       = (idx_ff + 1'b1 == eff_tc);

endmodule

// File: sv/gsp_checker.sv
`include "assert_macros.svh"

module gsp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [gsp_pkg::TIDX_W-1:0]      rsp_task_index,
   input logic [gsp_pkg::WORKER_W-1:0]    rsp_worker,
   input logic                            rsp_last
);

   // results only go out while loading is held off
   `GSP_ASSERT_IMPL(a_rsp_blocks_req, clock, reset, rsp_valid, req_stall)

   // reset leaves no result pending
   `GSP_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)

   // stalled word holds
   `GSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_task_index) && $stable(rsp_worker))

   // results of one batch come back to back in index order
   `GSP_ASSERT_NEXT(a_rsp_order, clock, reset, rsp_valid && !rsp_stall && !rsp_last, rsp_valid && (rsp_task_index == $past(rsp_task_index) + 4'd1))

   // batch ends on the last word
   `GSP_ASSERT_NEXT(a_rsp_end, clock, reset, rsp_valid && !rsp_stall && rsp_last, !rsp_valid)

endmodule

bind greedy_subset_sum_task_packer_unit gsp_checker u_gsp_checker (.*);
